>>> rtl/core/rsum_pkg.sv
// shared types and constants for the range-sum tree block
// no dependencies; imported by rsum_ctrl and range_sum_tree_point_assign
`default_nettype none

package rsum_pkg;

	localparam int POS_W   = 10;
	localparam int END_W   = 11;
	localparam int CNT_W   = 11;
	localparam int VAL_W   = 32;
	localparam int SUM_W   = 64;

	localparam logic FUNC_SET   = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	// one accepted item after range checks against the active count
	typedef struct packed {
		logic                    func;
		logic                    set_ok;
		logic                    query_ok;
		logic [POS_W-1:0]        position;
		logic [END_W-1:0]        range_end;
		logic signed [VAL_W-1:0] value;
	} cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/rsum_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module rsum_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

>>> rtl/core/rsum_ctrl.sv
// sequencer for the range-sum tree: clearing pass, leaf-to-root update and range walk
// uses rsum_pkg; drives one shared 64-bit adder and the node ram ports
`default_nettype none

module rsum_ctrl import rsum_pkg::*; #(
	parameter int CAPACITY = 1024
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                go,
	input  wire cmd_t                                cmd,
	output logic                                     busy,
	output logic                                     done,
	output logic signed [SUM_W-1:0]                  sum,
	output logic                                     ram_we,
	output logic        [$clog2(2*CAPACITY)-1:0]     ram_waddr,
	output logic        [SUM_W-1:0]                  ram_wdata,
	output logic        [$clog2(2*CAPACITY)-1:0]     ram_raddr,
	input  wire logic   [SUM_W-1:0]                  ram_rdata
);

	localparam int IW = $clog2(2*CAPACITY);
	localparam int NW = $clog2(2*CAPACITY+1);
	localparam logic [IW-1:0] LAST_NODE = IW'(2*CAPACITY-1);
	localparam logic [IW-1:0] ROOT      = IW'(1);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_CLR  = 6'b000010,
		ST_SRD  = 6'b000100,
		ST_SWR  = 6'b001000,
		ST_QLO  = 6'b010000,
		ST_QHI  = 6'b100000
	} state_t;

	state_t            state_q;
	logic [IW-1:0]     clr_q;
	logic [IW-1:0]     node_q;
	logic [SUM_W-1:0]  cur_q;
	logic [SUM_W-1:0]  acc_q;
	logic [NW-1:0]     lo_q;
	logic [NW-1:0]     hi_q;
	logic              pend_q;
	logic              done_q;
	logic [SUM_W-1:0]  sum_q;

	logic [SUM_W-1:0]  add_a;
	logic [SUM_W-1:0]  add_y;
	logic [SUM_W-1:0]  val_ext;
	logic [IW-1:0]     parent;
	logic [NW-1:0]     hi_dec;
	logic [NW-1:0]     hi_next;

	assign val_ext = {{(SUM_W-VAL_W){cmd.value[VAL_W-1]}}, cmd.value};
	assign parent  = node_q >> 1;
	assign hi_dec  = hi_q - NW'(1);
	assign hi_next = hi_q[0] ? hi_dec : hi_q;

	// the one shared adder: path update adds to the fresh child sum, query adds to acc
	assign add_a = (state_q == ST_SWR) ? cur_q : acc_q;
	assign add_y = add_a + ram_rdata;

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign sum  = sum_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_raddr = '0;
		case (state_q)
			ST_IDLE: begin
				if (go && cmd.func == FUNC_SET && cmd.set_ok) begin
					ram_we    = 1'b1;
					ram_waddr = IW'(CAPACITY) + IW'(cmd.position);
					ram_wdata = val_ext;
				end
			end
			ST_CLR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
			end
			ST_SRD: begin
				ram_raddr = node_q ^ ROOT;
			end
			ST_SWR: begin
				ram_we    = 1'b1;
				ram_waddr = parent;
				ram_wdata = add_y;
			end
			ST_QLO: begin
				ram_raddr = lo_q[IW-1:0];
			end
			ST_QHI: begin
				ram_raddr = hi_dec[IW-1:0];
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q   <= '0;
			pend_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (go) begin
						if (cmd.func == FUNC_QUERY) begin
							pend_q  <= 1'b0;
							state_q <= ST_QLO;
						end else if (cmd.set_ok) begin
							state_q <= ST_SRD;
						end
					end
				end
				ST_CLR: begin
					clr_q <= clr_q + IW'(1);
					if (clr_q == LAST_NODE) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SRD: begin
					state_q <= ST_SWR;
				end
				ST_SWR: begin
					if (parent == ROOT) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_SRD;
					end
				end
				ST_QLO: begin
					if (lo_q < hi_q) begin
						pend_q  <= lo_q[0];
						state_q <= ST_QHI;
					end else begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_QHI: begin
					pend_q  <= hi_q[0];
					state_q <= ST_QLO;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				acc_q  <= '0;
				cur_q  <= val_ext;
				node_q <= IW'(CAPACITY) + IW'(cmd.position);
				if (cmd.query_ok) begin
					lo_q <= NW'(CAPACITY) + NW'(cmd.position);
					hi_q <= NW'(CAPACITY) + NW'(cmd.range_end);
				end else begin
					lo_q <= '0;
					hi_q <= '0;
				end
			end
			ST_SWR: begin
				cur_q  <= add_y;
				node_q <= parent;
			end
			ST_QLO: begin
				if (pend_q) begin
					acc_q <= add_y;
				end
				if (lo_q < hi_q) begin
					if (lo_q[0]) begin
						lo_q <= lo_q + NW'(1);
					end
				end else begin
					sum_q <= pend_q ? add_y : acc_q;
				end
			end
			ST_QHI: begin
				if (pend_q) begin
					acc_q <= add_y;
				end
				lo_q <= lo_q >> 1;
				hi_q <= hi_next >> 1;
			end
			default: begin
				cur_q <= cur_q;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/core/range_sum_tree_point_assign.sv
// top level of the range-sum tree: count register, item range checks, node ram
// uses rsum_pkg, rsum_ram and rsum_ctrl
`default_nettype none

// Segment tree of 64-bit partial sums over CAPACITY signed 32-bit elements.
// Items: raise start with func, position, range_end and value; the item is taken
// at a rising edge where start is high and busy is low. busy stays high while the
// item is worked on. func set assigns one element and gives no result; func query
// gives one result: sum is valid while done is high for exactly one cycle.
// Set: the leaf is written at acceptance, then one parent per tree level, each by
// a sibling read followed by an add and write. Query: the range walk takes a low
// and a high step per level and ends in a low step that finds the range empty;
// done follows the last busy cycle. Both use the single ram read port and the one
// shared adder. Sets outside the active count are dropped without going busy;
// empty ranges end the query walk in its first step (query gives 0).
// active_count is written through cfg_we/cfg_wdata at any edge; change it only
// while the block is idle. Reset sets it to 1024 and starts a clearing pass
// that writes zero to every node, during which busy is high.
// The receiver cannot stall: each result is flagged by done for one cycle only.

module range_sum_tree_point_assign import rsum_pkg::*; #(
	parameter int CAPACITY = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic                     func,
	input  wire logic [POS_W-1:0]         position,
	input  wire logic [END_W-1:0]         range_end,
	input  wire logic signed [VAL_W-1:0]  value,
	output logic                          done,
	output logic signed [SUM_W-1:0]       sum,
	input  wire logic                     cfg_we,
	input  wire logic [CNT_W-1:0]         cfg_wdata
);

	localparam int IW  = $clog2(2*CAPACITY);
	localparam int CW0 = $clog2(CAPACITY+1);
	localparam int CW  = (CW0 > CNT_W) ? CW0 : CNT_W;
	localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(1024);

	logic [CNT_W-1:0] active_count_q;
	logic [CW-1:0]    eff_count;
	logic [CW-1:0]    end_clamp;
	logic [CW-1:0]    pos_w;
	logic [CW-1:0]    end_w;
	logic             go;
	cmd_t             cmd;

	logic             ram_we;
	logic [IW-1:0]    ram_waddr;
	logic [SUM_W-1:0] ram_wdata;
	logic [IW-1:0]    ram_raddr;
	logic [SUM_W-1:0] ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_count_q <= COUNT_RESET;
		end else if (cfg_we) begin
			active_count_q <= cfg_wdata;
		end
	end

	assign pos_w     = CW'(position);
	assign end_w     = CW'(range_end);
	assign eff_count = (CW'(active_count_q) > CW'(CAPACITY)) ? CW'(CAPACITY)
	                   : CW'(active_count_q);
	assign end_clamp = (end_w > eff_count) ? eff_count : end_w;

	assign go           = start && !busy;
	assign cmd.func     = func;
	assign cmd.set_ok   = (pos_w < eff_count);
	assign cmd.query_ok = (pos_w < end_clamp);
	assign cmd.position = position;
	// clamped end never exceeds the raw end, so it fits the field
	assign cmd.range_end = END_W'(end_clamp);
	assign cmd.value    = value;

	rsum_ctrl #(
		.CAPACITY (CAPACITY)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (go),
		.cmd       (cmd),
		.busy      (busy),
		.done      (done),
		.sum       (sum),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	rsum_ram #(
		.WIDTH (SUM_W),
		.DEPTH (2*CAPACITY)
	) u_nodes (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

`ifndef SYNTHESIS
	a_done_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_query_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(go && func == FUNC_QUERY) |=> busy)
		else $error("query item not taken into the walk");

	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a preceding query walk");

	a_no_write_on_query_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && $past(go && func == FUNC_QUERY)) |-> !ram_we)
		else $error("node store written during a query");
`endif

endmodule

`default_nettype wire

>>> tb/rsum_checker.sv
`timescale 1ns / 100ps
// watches items, count writes and results of range_sum_tree_point_assign
// keeps its own copy of the element array and checks each sum; uses rsum_pkg

module rsum_checker import rsum_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic                    busy,
	input  wire logic                    func,
	input  wire logic [POS_W-1:0]        position,
	input  wire logic [END_W-1:0]        range_end,
	input  wire logic signed [VAL_W-1:0] value,
	input  wire logic                    done,
	input  wire logic signed [SUM_W-1:0] sum,
	input  wire logic                    cfg_we,
	input  wire logic [CNT_W-1:0]        cfg_wdata,
	output int                           errors,
	output int                           pending
);

	localparam int SLOTS = 1024;

	logic signed [VAL_W-1:0] elem_val [0:SLOTS-1];
	logic [CNT_W-1:0]        count_reg;
	logic signed [SUM_W-1:0] expected_sums [$];

	// plain running total over [lo, hi), wraps at 64 bits
	function automatic logic signed [SUM_W-1:0] span_total(input int lo, input int hi);
		logic signed [SUM_W-1:0] acc;
		acc = '0;
		for (int i = lo; i < hi; i++)
			acc = acc + {{(SUM_W-VAL_W){elem_val[i][VAL_W-1]}}, elem_val[i]};
		return acc;
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("%0t rsum_checker: %s", $time, msg);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		int                      eff;
		int                      hi;
		logic signed [SUM_W-1:0] want;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++)
				elem_val[i] = '0;
			count_reg = 11'd1024;
			expected_sums.delete();
			errors = 0;
		end else begin
			// item uses the count in force before any write at the same edge
			if (start && !busy) begin
				eff = (count_reg > SLOTS) ? SLOTS : count_reg;
				if (func == FUNC_SET) begin
					if (position < eff)
						elem_val[position] = value;
				end else begin
					hi = (range_end > eff) ? eff : range_end;
					want = (position < hi) ? span_total(position, hi) : '0;
					expected_sums.push_back(want);
				end
			end
			if (cfg_we)
				count_reg = cfg_wdata;
			if (done) begin
				if (expected_sums.size() == 0) begin
					flag_mismatch($sformatf("unexpected result, sum %0d", sum));
				end else begin
					want = expected_sums.pop_front();
					if (sum !== want)
						flag_mismatch($sformatf("sum got %0d expected %0d", sum, want));
				end
			end
		end
		pending = expected_sums.size();
	end

endmodule

>>> tb/tb_range_sum_tree_point_assign.sv
`timescale 1ns / 100ps
// stimulus and verdict for range_sum_tree_point_assign
// depends on rsum_pkg, the block itself and rsum_checker

module tb_range_sum_tree_point_assign import rsum_pkg::*; ();

	logic                    clk;
	logic                    arst_n    = 1'b0;
	logic                    start     = 1'b0;
	logic                    func      = FUNC_SET;
	logic [POS_W-1:0]        position  = '0;
	logic [END_W-1:0]        range_end = '0;
	logic signed [VAL_W-1:0] value     = '0;
	logic                    cfg_we    = 1'b0;
	logic [CNT_W-1:0]        cfg_wdata = '0;
	logic                    busy;
	logic                    done;
	logic signed [SUM_W-1:0] sum;
	int                      fail_count;
	int                      open_sums;
	int                      max_gap   = 3;

	range_sum_tree_point_assign #(.CAPACITY(1024)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.func      (func),
		.position  (position),
		.range_end (range_end),
		.value     (value),
		.done      (done),
		.sum       (sum),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	rsum_checker sum_watch (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.func      (func),
		.position  (position),
		.range_end (range_end),
		.value     (value),
		.done      (done),
		.sum       (sum),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.errors    (fail_count),
		.pending   (open_sums)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// start stays high into the next item when no gap is drawn
	task automatic send_item(input logic f, input int p, input int e, input logic [31:0] v);
		int gap;
		func      <= f;
		position  <= p[POS_W-1:0];
		range_end <= e[END_W-1:0];
		value     <= v;
		start     <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		gap = $urandom_range(0, max_gap);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_random(input int cnt);
		int          eff;
		int          p;
		int          e;
		logic        f;
		logic [31:0] v;
		eff = (cnt > 1024) ? 1024 : cnt;
		f = $urandom_range(0, 1) ? FUNC_QUERY : FUNC_SET;
		if (eff != 0 && $urandom_range(0, 3) != 0)
			p = $urandom_range(0, eff - 1);
		else
			p = $urandom_range(0, 1023);
		if (eff > p && $urandom_range(0, 3) != 0)
			e = $urandom_range(p, eff);
		else
			e = $urandom_range(0, 2047);
		case ($urandom_range(0, 7))
			0: v = 32'h7fff_ffff;
			1: v = 32'h8000_0000;
			2: v = $urandom_range(0, 16) - 8;
			default: v = $urandom();
		endcase
		send_item(f, p, e, v);
	endtask

	// drain results, then give a pending set time to finish its tree walk
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (open_sums != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic write_count(input int c);
		cfg_wdata <= c[CNT_W-1:0];
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic run_phase(input int cnt, input int n, input int gaps);
		settle();
		write_count(cnt);
		max_gap = gaps;
		repeat (n) send_random(cnt);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// cleared store, extremes of value, empty and clamped spans
		send_item(FUNC_QUERY, 0, 1024, 32'h0);
		send_item(FUNC_SET, 0, 0, 32'h7fff_ffff);
		send_item(FUNC_SET, 1023, 0, 32'h8000_0000);
		send_item(FUNC_SET, 512, 0, 32'hffff_ffff);
		send_item(FUNC_SET, 1, 2047, 32'h5555_5555);
		send_item(FUNC_SET, 1022, 0, 32'haaaa_aaaa);
		send_item(FUNC_QUERY, 0, 1024, 32'h0);
		send_item(FUNC_QUERY, 0, 1, 32'h0);
		send_item(FUNC_QUERY, 1023, 1024, 32'h0);
		send_item(FUNC_QUERY, 0, 0, 32'h0);
		send_item(FUNC_QUERY, 700, 300, 32'hffff_ffff);
		send_item(FUNC_QUERY, 1023, 2047, 32'h0);
		send_item(FUNC_QUERY, 1, 1023, 32'h0);
		send_item(FUNC_QUERY, 512, 513, 32'h0);
		send_item(FUNC_SET, 512, 0, 32'h0);
		send_item(FUNC_QUERY, 256, 768, 32'h0);
		send_item(FUNC_QUERY, 1022, 2047, 32'h0);

		// zero count: sets dropped, every query empty
		settle();
		write_count(0);
		send_item(FUNC_SET, 5, 0, 32'h1234_5678);
		send_item(FUNC_QUERY, 0, 1024, 32'h0);
		send_item(FUNC_QUERY, 0, 2047, 32'h0);

		// lowered count hides elements, raising it brings them back
		settle();
		write_count(3);
		send_item(FUNC_QUERY, 0, 1024, 32'h0);
		send_item(FUNC_SET, 1023, 0, 32'h0000_0001);
		settle();
		write_count(1024);
		send_item(FUNC_QUERY, 1023, 1024, 32'h0);
		send_item(FUNC_QUERY, 0, 1024, 32'h0);

		run_phase(2047, 110, 3);
		run_phase(1, 40, 3);
		run_phase($urandom_range(2, 16), 110, 0);
		run_phase($urandom_range(1, 1024), 130, 3);
		run_phase(0, 20, 3);
		run_phase($urandom_range(1, 2047), 120, 3);
		run_phase(1024, 130, 3);

		settle();
		if (fail_count == 0) begin
			$display("tb_range_sum_tree_point_assign: done, clean");
		end else begin
			$display("tb_range_sum_tree_point_assign: done, errors");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("tb_range_sum_tree_point_assign: done, errors");
		$finish;
	end

endmodule
